// ----- design/edd8_pkg.sv -----
// Shared constants for the error-diffusion dither block.
`timescale 1ns / 1ps
package edd8_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int IN_BITS_DEF   = 14;

	localparam int          LW_BITS  = 13;
	localparam logic [12:0] LW_RESET = 13'd640;

	// where the stored error of a pixel comes from
	localparam logic [1:0] SRC_ZERO = 2'd0;
	localparam logic [1:0] SRC_MEM  = 2'd1;
	localparam logic [1:0] SRC_FWD  = 2'd2;

endpackage

// ----- design/error_diffusion_dither_to_8bit.sv -----
// Path: an accepted pixel is registered in stage 1, then in the output registers.
// Throughput: one pixel per cycle unless the output stalls; the error line sits in two banks (even and odd
// columns), each with one read and one write port, so both writes of a row end happen in the same cycle.
// Reset: line width 640, carries and column cleared; the error line is not swept,
// a fill count marks the written prefix and start of image resets it.
`timescale 1ns / 1ps
module error_diffusion_dither_to_8bit #(
	parameter int MAX_WIDTH = edd8_pkg::MAX_WIDTH_DEF,
	parameter int IN_BITS   = edd8_pkg::IN_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [edd8_pkg::LW_BITS-1:0] cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [IN_BITS-1:0]           pixel_in,
	input  logic                         start_of_image,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   pixel_out,
	output logic                         end_of_row
);
	import edd8_pkg::*;

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WC_W       = COL_W + 1;
	localparam int SHIFT_W    = IN_BITS - 8;
	localparam int SUM_W      = IN_BITS + 1;
	localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	logic [LW_BITS-1:0] line_width_q;
	logic [WC_W-1:0]    w_eff;

	logic [COL_W-1:0]   column_count_q;
	logic [WC_W-1:0]    fill_q;
	logic [SHIFT_W-1:0] rc_q, dl_q;

	logic               valid_s1;
	logic [IN_BITS-1:0] pix_s1;
	logic               sof_s1, last_s1;
	logic [COL_W-1:0]   col_s1;
	logic [1:0]         src_s1;
	logic [SHIFT_W-1:0] fwd_s1;
	logic [SHIFT_W-1:0] rd_even_s1, rd_odd_s1;

	logic               out_valid_q, end_of_row_q;
	logic [7:0]         pixel_out_q;

	logic [SHIFT_W-1:0] err_even_mem [BANK_DEPTH];
	logic [SHIFT_W-1:0] err_odd_mem  [BANK_DEPTH];

	logic               acc, s1_adv;
	logic [COL_W-1:0]   col_s0;
	logic               last_s0;
	logic [1:0]         src_s0;
	logic [SHIFT_W-1:0] fwd_s0;
	logic [BANK_AW-1:0] rd_addr;

	logic [SHIFT_W-1:0] rc_eff, dl_eff, entry, err, quarter, half, down;
	logic [SUM_W-1:0]   sum;
	logic [IN_BITS-1:0] clamped;
	logic [COL_W-1:0]   col_m1;
	logic               wr_dl, wr_last;
	logic               we_even, we_odd;
	logic [BANK_AW-1:0] wa_even, wa_odd;
	logic [SHIFT_W-1:0] wd_even, wd_odd;
	logic [WC_W-1:0]    fill_cand;

	// configured width, held in 1..MAX_WIDTH
	always_comb begin
		if (line_width_q == '0) begin
			w_eff = WC_W'(1);
		end else if (32'(line_width_q) > MAX_WIDTH) begin
			w_eff = WC_W'(MAX_WIDTH);
		end else begin
			w_eff = WC_W'(line_width_q);
		end
	end

	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign acc      = in_valid && in_ready;

	// ---------------- stage 0: column, row end, memory read ----------------
	assign col_s0  = start_of_image ? '0 : column_count_q;
	assign last_s0 = ({1'b0, col_s0} + WC_W'(1)) >= w_eff;
	assign rd_addr = BANK_AW'(col_s0 >> 1);

	// ---------------- stage 1: add, clamp, split error ----------------
	assign rc_eff = sof_s1 ? '0 : rc_q;
	assign dl_eff = sof_s1 ? '0 : dl_q;

	always_comb begin
		case (src_s1)
			SRC_MEM:  entry = col_s1[0] ? rd_odd_s1 : rd_even_s1;
			SRC_FWD:  entry = fwd_s1;
			default:  entry = '0;
		endcase
	end

	assign sum     = {1'b0, pix_s1} + SUM_W'(entry) + SUM_W'(rc_eff);
	assign clamped = sum[IN_BITS] ? {IN_BITS{1'b1}} : sum[IN_BITS-1:0];
	assign err     = clamped[SHIFT_W-1:0];
	assign quarter = err >> 2;
	assign half    = err >> 1;
	assign down    = dl_eff + quarter;

	assign col_m1  = col_s1 - COL_W'(1);
	assign wr_dl   = col_s1 != '0;
	assign wr_last = last_s1;

	// the two writes of a row end land in different banks
	always_comb begin
		we_even = 1'b0;
		wa_even = BANK_AW'(col_m1 >> 1);
		wd_even = down;
		we_odd  = 1'b0;
		wa_odd  = BANK_AW'(col_m1 >> 1);
		wd_odd  = down;
		if (wr_last && !col_s1[0]) begin
			we_even = s1_adv;
			wa_even = BANK_AW'(col_s1 >> 1);
			wd_even = quarter;
		end else if (wr_dl && !col_m1[0]) begin
			we_even = s1_adv;
		end
		if (wr_last && col_s1[0]) begin
			we_odd = s1_adv;
			wa_odd = BANK_AW'(col_s1 >> 1);
			wd_odd = quarter;
		end else if (wr_dl && col_m1[0]) begin
			we_odd = s1_adv;
		end
	end

	// read source for the incoming pixel; forward what stage 1 writes this cycle
	always_comb begin
		fwd_s0 = '0;
		if (start_of_image) begin
			src_s0 = SRC_ZERO;
		end else if (s1_adv && wr_dl && (col_m1 == col_s0)) begin
			src_s0 = SRC_FWD;
			fwd_s0 = down;
		end else if (s1_adv && wr_last && (col_s1 == col_s0)) begin
			src_s0 = SRC_FWD;
			fwd_s0 = quarter;
		end else if ({1'b0, col_s0} < fill_q) begin
			src_s0 = SRC_MEM;
		end else begin
			src_s0 = SRC_ZERO;
		end
	end

	assign fill_cand = last_s1 ? ({1'b0, col_s1} + WC_W'(1)) : {1'b0, col_s1};

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (we_even) begin
			err_even_mem[wa_even] <= wd_even;
		end
		if (acc) begin
			rd_even_s1 <= err_even_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we_odd) begin
			err_odd_mem[wa_odd] <= wd_odd;
		end
		if (acc) begin
			rd_odd_s1 <= err_odd_mem[rd_addr];
		end
	end

	// ---------------- control and state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LW_RESET;
			column_count_q <= '0;
			fill_q         <= '0;
			rc_q           <= '0;
			dl_q           <= '0;
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				line_width_q <= cfg_wdata;
			end
			if (acc) begin
				column_count_q <= last_s0 ? '0 : (col_s0 + COL_W'(1));
			end
			if (s1_adv) begin
				if (fill_cand > fill_q) begin
					fill_q <= fill_cand;
				end
				if (last_s1) begin
					rc_q <= '0;
					dl_q <= '0;
				end else begin
					rc_q <= half;
					dl_q <= quarter;
				end
			end
			// image start drops everything written before
			if (acc && start_of_image) begin
				fill_q <= '0;
			end
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= pixel_in;
			sof_s1  <= start_of_image;
			col_s1  <= col_s0;
			last_s1 <= last_s0;
			src_s1  <= src_s0;
			fwd_s1  <= fwd_s0;
		end
		if (s1_adv) begin
			pixel_out_q  <= clamped[IN_BITS-1:SHIFT_W];
			end_of_row_q <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_out_q;
	assign end_of_row = end_of_row_q;

`ifndef SYNTHESIS
	a_accept_slot: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (!valid_s1 || s1_adv))
		else $error("pixel accepted while stage 1 holds");

	a_sof_clears_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && start_of_image) |=> (fill_q == '0))
		else $error("fill count not cleared at image start");

	a_row_end_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && last_s1) |=> (rc_q == '0 && dl_q == '0))
		else $error("carries survive a row end");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= MAX_WIDTH)
		else $error("fill count beyond line store");

	a_single_bank_hit: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_adv && wr_last && wr_dl && (col_s1[0] == col_m1[0])))
		else $error("two writes to one bank");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the error-diffusion dither to 8 bits.
`timescale 1ns / 1ps
module tb_top;
	import edd8_pkg::*;

	localparam int          MAX_W       = MAX_WIDTH_DEF;
	localparam int unsigned PIX_MAX     = (1 << IN_BITS_DEF) - 1;
	localparam int unsigned ERR_MASK    = (1 << (IN_BITS_DEF - 8)) - 1;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          HOLD_CYCLES = 250;

	typedef struct packed {
		logic [IN_BITS_DEF-1:0] pix;
		logic                   sof;
	} pixel_item_t;

	typedef struct {
		logic [7:0] pix;
		logic       eor;
	} dither_res_t;

	logic                   clk            = 1'b0;
	logic                   arst_n         = 1'b0;
	logic                   cfg_we         = 1'b0;
	logic [LW_BITS-1:0]     cfg_wdata      = '0;
	logic                   in_valid       = 1'b0;
	logic                   in_ready;
	logic [IN_BITS_DEF-1:0] pixel_in       = '0;
	logic                   start_of_image = 1'b0;
	logic                   out_valid;
	logic                   out_ready      = 1'b0;
	logic [7:0]             pixel_out;
	logic                   end_of_row;

	error_diffusion_dither_to_8bit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pixel_in       (pixel_in),
		.start_of_image (start_of_image),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_out      (pixel_out),
		.end_of_row     (end_of_row)
	);

	always #2 clk = ~clk;

	// predictor state
	int unsigned       err_row [MAX_W];
	int unsigned       right_share;
	int unsigned       below_left_share;
	int unsigned       next_col;
	logic [LW_BITS-1:0] line_width_reg = LW_RESET;

	pixel_item_t pixel_q [$];
	dither_res_t dither_q [$];

	int   mismatches = 0;
	int   cycle_cnt  = 0;
	logic pix_fire   = 1'b0;
	int   idle_rate  = 0;   // percent chance per cycle of starting an idle burst
	bit   hold_phase = 1'b0;

	function automatic void clear_image();
		foreach (err_row[i])
			err_row[i] = 0;
		right_share      = 0;
		below_left_share = 0;
		next_col         = 0;
	endfunction

	function automatic void dither_pixel(input logic [IN_BITS_DEF-1:0] pix, input logic sof,
		output dither_res_t r);
		int unsigned w, col, sum, err, quarter;
		w = line_width_reg;
		if (w < 1)
			w = 1;
		if (w > MAX_W)
			w = MAX_W;
		if (sof)
			clear_image();
		col = next_col;
		if (col >= MAX_W)
			col = MAX_W - 1;
		sum = pix + err_row[col] + right_share;
		if (sum > PIX_MAX)
			sum = PIX_MAX;
		r.pix   = 8'(sum >> (IN_BITS_DEF - 8));
		err     = sum & ERR_MASK;
		quarter = err / 4;
		if (col > 0)
			err_row[col - 1] = below_left_share + quarter;
		r.eor = (col + 1 >= w);
		if (r.eor) begin
			err_row[col]     = quarter;
			right_share      = 0;
			below_left_share = 0;
			next_col         = 0;
		end else begin
			below_left_share = quarter;
			right_share      = err / 2;
			next_col         = col + 1;
		end
	endfunction

	function automatic logic [IN_BITS_DEF-1:0] rand_pix();
		case ($urandom_range(0, 5))
			0: return IN_BITS_DEF'($urandom_range(PIX_MAX - 63, PIX_MAX));
			1: return IN_BITS_DEF'($urandom_range(0, 63));
			default: return IN_BITS_DEF'($urandom());
		endcase
	endfunction

	// driver: payload changes only when no transaction is pending
	pixel_item_t nxt_item;
	int          gap_left = 0;

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !pix_fire)) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
				in_valid <= 1'b0;
				gap_left <= $urandom_range(0, 11);
			end else if (pixel_q.size() != 0) begin
				nxt_item = pixel_q.pop_front();
				in_valid       <= 1'b1;
				pixel_in       <= nxt_item.pix;
				start_of_image <= nxt_item.sof;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side back-pressure
	int stall_left = 0;
	int hold_left  = 0;
	bit hold_used  = 1'b0;

	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_phase && !hold_used) begin
			out_ready <= 1'b0;
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 11);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: predict on input transaction, check on output transaction
	dither_res_t exp_res, got_res;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL error_diffusion_dither_to_8bit");
			$finish;
		end else begin
			pix_fire <= in_valid && in_ready;
			if (arst_n && in_valid && in_ready) begin
				dither_pixel(pixel_in, start_of_image, exp_res);
				dither_q.push_back(exp_res);
			end
			if (arst_n && out_valid && out_ready) begin
				if (dither_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected output transaction: pixel_out %0d end_of_row %0d",
							pixel_out, end_of_row);
					mismatches++;
				end else begin
					got_res = dither_q.pop_front();
					if (pixel_out !== got_res.pix || end_of_row !== got_res.eor) begin
						if (mismatches < 10)
							$display("mismatch: pixel_out exp %0d got %0d, end_of_row exp %0d got %0d",
								got_res.pix, pixel_out, got_res.eor, end_of_row);
						mismatches++;
					end
				end
			end
		end
	end

	task automatic wait_idle();
		while (pixel_q.size() != 0 || in_valid || dither_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_width(input int unsigned v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v[LW_BITS-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		line_width_reg = v[LW_BITS-1:0];
	endtask

	task automatic push_px(input int unsigned pix, input bit sof);
		pixel_item_t it;
		it.pix = pix[IN_BITS_DEF-1:0];
		it.sof = sof;
		pixel_q.push_back(it);
	endtask

	// random pixels; a rare stray start of image breaks up the raster
	task automatic queue_pixels(input int n, input bit sof_first);
		for (int i = 0; i < n; i++)
			push_px(rand_pix(), (i == 0) ? sof_first : ($urandom_range(0, 299) == 0));
	endtask

	function automatic int eff_width(input int unsigned v);
		if (v == 0)
			return 1;
		if (v > MAX_W)
			return MAX_W;
		return v;
	endfunction

	int          rand_items;
	int unsigned wv;
	int          eff, n, imgs;

	initial begin
		clear_image();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// straight out of reset, width 640, no start flag: stored errors read as zero
		push_px(PIX_MAX, 0);
		push_px(PIX_MAX, 0);
		push_px(PIX_MAX, 0);
		push_px(0, 0);
		push_px(63, 0);
		push_px(64, 0);
		push_px(14'h2AAA, 0);
		push_px(14'h1555, 0);
		wait_idle();

		// width 0 behaves as 1: every pixel ends its row
		set_width(0);
		push_px(PIX_MAX, 1);
		push_px(100, 0);
		push_px(PIX_MAX, 0);
		push_px(63, 0);
		wait_idle();

		// width 3, stop one pixel into a row, then shrink to 2 mid-row
		set_width(3);
		push_px(PIX_MAX - 3, 1);
		push_px(PIX_MAX, 0);
		push_px(1, 0);
		push_px(2, 0);
		push_px(PIX_MAX, 0);
		push_px(0, 0);
		push_px(63, 0);
		wait_idle();
		set_width(2);
		push_px(PIX_MAX, 0);
		push_px(PIX_MAX, 0);
		push_px(5, 0);
		push_px(0, 0);
		wait_idle();

		// random images over a spread of widths and idle densities
		rand_items = 0;
		while (rand_items < 1150) begin
			case ($urandom_range(0, 19))
				0: wv = 0;
				1: wv = $urandom_range(MAX_W + 1, (1 << LW_BITS) - 1);
				2, 3: wv = $urandom_range(100, 400);
				default: wv = $urandom_range(1, 24);
			endcase
			case ($urandom_range(0, 2))
				0: idle_rate = 0;
				1: idle_rate = 8;
				default: idle_rate = 30;
			endcase
			set_width(wv);
			eff  = eff_width(wv);
			imgs = (eff > 24) ? 1 : $urandom_range(1, 3);
			for (int k = 0; k < imgs; k++) begin
				if (eff >= MAX_W)
					n = $urandom_range(10, 60);
				else if (eff > 24)
					n = eff * $urandom_range(1, 2) + $urandom_range(0, 3);
				else
					n = eff * $urandom_range(1, 5) +
						(($urandom_range(0, 3) == 0) ? $urandom_range(0, eff - 1) : 0);
				// sometimes carry on from the previous phase without a start flag
				queue_pixels(n, $urandom_range(0, 7) != 0);
				rand_items += n;
			end
			wait_idle();
		end

		// long output stall while the input keeps offering
		idle_rate = 0;
		set_width(8);
		queue_pixels(150, 1);
		hold_phase = 1'b1;
		wait_idle();
		hold_phase = 1'b0;

		// widest rows: top register value clips to the maximum width
		idle_rate = 5;
		set_width((1 << LW_BITS) - 1);
		queue_pixels(60, 1);
		wait_idle();
		set_width(MAX_W);
		queue_pixels(40, 1);
		wait_idle();

		// closing stretch with no idling at all
		idle_rate = 0;
		set_width(7);
		queue_pixels(300, 1);
		wait_idle();
		repeat (8) @(posedge clk);

		if (mismatches == 0 && dither_q.size() == 0)
			$display("PASS error_diffusion_dither_to_8bit");
		else
			$display("FAIL error_diffusion_dither_to_8bit");
		$finish;
	end

endmodule
